// ===== rtl/rmdg_pkg.sv =====
package rmdg_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 14;

	localparam int IN_W       = 16;
	localparam int OUT_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	localparam int STEPS      = 32;
	localparam int WORK_FRAC  = 30;
	localparam int WORK_W     = 33;
	localparam int RND_SH     = WORK_FRAC - FRAC_BITS;
	localparam int ANGLE_SH   = 32 - ANGLE_BITS;

	localparam logic [31:0] ANGLE_MASK =
		(ANGLE_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ANGLE_BITS) - 64'd1);

	localparam logic signed [WORK_W-1:0] X_INIT = WORK_W'(652032874);

	// output limits: +-1.0 in Q format, then the 16-bit range
	localparam longint ONE_L    = longint'(1) << FRAC_BITS;
	localparam longint CLAMP_HI = (ONE_L > 32767) ? 32767 : ONE_L;
	localparam longint CLAMP_LO = (-ONE_L < -32768) ? -32768 : -ONE_L;

	localparam logic signed [WORK_W-1:0] LIM_HI_W = WORK_W'(CLAMP_HI);
	localparam logic signed [WORK_W-1:0] LIM_LO_W = WORK_W'(CLAMP_LO);
	localparam logic signed [OUT_W-1:0]  OUT_HI   = OUT_W'(CLAMP_HI);
	localparam logic signed [OUT_W-1:0]  OUT_LO   = OUT_W'(CLAMP_LO);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AXIS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd1;

	localparam logic [CFG_DATA_W-1:0] AXIS_X = 2'd0;
	localparam logic [CFG_DATA_W-1:0] AXIS_Y = 2'd1;
	localparam logic [CFG_DATA_W-1:0] AXIS_Z = 2'd2;

	localparam logic [CFG_DATA_W-1:0] ORDER_FIRST  = 2'd1;
	localparam logic [CFG_DATA_W-1:0] ORDER_SECOND = 2'd2;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	typedef logic signed [OUT_W-1:0] entry_t;

	typedef struct packed {
		logic signed [WORK_W-1:0] x;
		logic signed [WORK_W-1:0] y;
		logic signed [WORK_W-1:0] z;
		logic [1:0]               quad;
	} cordic_t;

	// atan(2^-i) as a fraction of a full turn, 2^32 per turn
	function automatic logic signed [WORK_W-1:0] atan_turns(input int i);
		logic signed [WORK_W-1:0] t;
		case (i)
			0:  t = WORK_W'(536870912);
			1:  t = WORK_W'(316933406);
			2:  t = WORK_W'(167458907);
			3:  t = WORK_W'(85004756);
			4:  t = WORK_W'(42667331);
			5:  t = WORK_W'(21354465);
			6:  t = WORK_W'(10679838);
			7:  t = WORK_W'(5340245);
			8:  t = WORK_W'(2670163);
			9:  t = WORK_W'(1335087);
			10: t = WORK_W'(667544);
			11: t = WORK_W'(333772);
			12: t = WORK_W'(166886);
			13: t = WORK_W'(83443);
			14: t = WORK_W'(41722);
			15: t = WORK_W'(20861);
			16: t = WORK_W'(10430);
			17: t = WORK_W'(5215);
			18: t = WORK_W'(2608);
			19: t = WORK_W'(1304);
			20: t = WORK_W'(652);
			21: t = WORK_W'(326);
			22: t = WORK_W'(163);
			23: t = WORK_W'(81);
			24: t = WORK_W'(41);
			25: t = WORK_W'(20);
			26: t = WORK_W'(10);
			27: t = WORK_W'(5);
			28: t = WORK_W'(3);
			29: t = WORK_W'(1);
			30: t = WORK_W'(1);
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/rotation_matrix_derivative_gen.sv =====
// Derivative of the 3x3 elementary rotation matrix about axis X, Y or Z (first or second
// order, set by the two config registers) for a stream of angles given as fractions of a
// full turn. Entries are Q1.14. Throughput is one angle per clock when out_ready is high; each
// result passes an input stage, the 32-stage unrolled CORDIC (one micro-rotation per stage),
// a quadrant-fold stage, a rounding stage and the matrix output register. Every stage stalls
// only when the stage after it is full and cannot move on, so bubbles close up under output
// back-pressure. cfg_ready is always high; write the registers only while no request is in
// flight.
module rotation_matrix_derivative_gen (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [rmdg_pkg::IN_W-1:0]            angle_turns,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [rmdg_pkg::OUT_W-1:0]    m00,
	output logic signed [rmdg_pkg::OUT_W-1:0]    m01,
	output logic signed [rmdg_pkg::OUT_W-1:0]    m02,
	output logic signed [rmdg_pkg::OUT_W-1:0]    m10,
	output logic signed [rmdg_pkg::OUT_W-1:0]    m11,
	output logic signed [rmdg_pkg::OUT_W-1:0]    m12,
	output logic signed [rmdg_pkg::OUT_W-1:0]    m20,
	output logic signed [rmdg_pkg::OUT_W-1:0]    m21,
	output logic signed [rmdg_pkg::OUT_W-1:0]    m22,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rmdg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rmdg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int ST_MAP = rmdg_pkg::STEPS + 1;
	localparam int ST_RND = rmdg_pkg::STEPS + 2;
	localparam int ST_OUT = rmdg_pkg::STEPS + 3;

	logic [rmdg_pkg::CFG_DATA_W-1:0] axis_q;
	logic [rmdg_pkg::CFG_DATA_W-1:0] order_q;

	logic                vld_s [0:ST_OUT];
	logic                rdy   [0:ST_OUT+1];
	rmdg_pkg::cordic_t   cord_s [0:rmdg_pkg::STEPS];

	logic signed [rmdg_pkg::WORK_W-1:0] cos_s33, sin_s33;
	rmdg_pkg::entry_t                   cos_s34, sin_s34;
	rmdg_pkg::entry_t                   m_s35 [0:8];

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q  <= rmdg_pkg::AXIS_X;
			order_q <= rmdg_pkg::ORDER_FIRST;
		end else if (cfg_valid) begin
			case (cfg_index)
				rmdg_pkg::REG_AXIS:  axis_q  <= cfg_data;
				rmdg_pkg::REG_ORDER: order_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage takes new data when it is empty or its contents move on
	assign rdy[ST_OUT+1] = out_ready;
	for (genvar k = 0; k <= ST_OUT; k++) begin : g_rdy
		assign rdy[k] = !vld_s[k] || rdy[k+1];
	end
	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	for (genvar k = 1; k <= ST_OUT; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// input stage: place the angle in a 32-bit turn, split off the quadrant
	logic [31:0] turn32;
	assign turn32 = (32'(angle_turns) & rmdg_pkg::ANGLE_MASK) << rmdg_pkg::ANGLE_SH;

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			cord_s[0].x    <= rmdg_pkg::X_INIT;
			cord_s[0].y    <= '0;
			cord_s[0].z    <= rmdg_pkg::WORK_W'(turn32[29:0]);
			cord_s[0].quad <= turn32[31:30];
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < rmdg_pkg::STEPS; i++) begin : g_iter
		logic signed [rmdg_pkg::WORK_W-1:0] dx, dy;
		assign dx = cord_s[i].y >>> i;
		assign dy = cord_s[i].x >>> i;

		always_ff @(posedge clk) begin
			if (rdy[i+1] && vld_s[i]) begin
				if (!cord_s[i].z[rmdg_pkg::WORK_W-1]) begin
					cord_s[i+1].x <= cord_s[i].x - dx;
					cord_s[i+1].y <= cord_s[i].y + dy;
					cord_s[i+1].z <= cord_s[i].z - rmdg_pkg::atan_turns(i);
				end else begin
					cord_s[i+1].x <= cord_s[i].x + dx;
					cord_s[i+1].y <= cord_s[i].y - dy;
					cord_s[i+1].z <= cord_s[i].z + rmdg_pkg::atan_turns(i);
				end
				cord_s[i+1].quad <= cord_s[i].quad;
			end
		end
	end

	// quadrant fold
	always_ff @(posedge clk) begin
		if (rdy[ST_MAP] && vld_s[rmdg_pkg::STEPS]) begin
			case (cord_s[rmdg_pkg::STEPS].quad)
				rmdg_pkg::QUAD_0: begin
					cos_s33 <= cord_s[rmdg_pkg::STEPS].x;
					sin_s33 <= cord_s[rmdg_pkg::STEPS].y;
				end
				rmdg_pkg::QUAD_1: begin
					cos_s33 <= -cord_s[rmdg_pkg::STEPS].y;
					sin_s33 <= cord_s[rmdg_pkg::STEPS].x;
				end
				rmdg_pkg::QUAD_2: begin
					cos_s33 <= -cord_s[rmdg_pkg::STEPS].x;
					sin_s33 <= -cord_s[rmdg_pkg::STEPS].y;
				end
				default: begin
					cos_s33 <= cord_s[rmdg_pkg::STEPS].y;
					sin_s33 <= -cord_s[rmdg_pkg::STEPS].x;
				end
			endcase
		end
	end

	// round half up to the output scale, then clamp
	logic signed [rmdg_pkg::WORK_W-1:0] cos_rnd, sin_rnd;
	rmdg_pkg::entry_t                   cos_lim, sin_lim;

	if (rmdg_pkg::RND_SH > 0) begin : g_rnd
		localparam logic signed [rmdg_pkg::WORK_W-1:0] HALF =
			rmdg_pkg::WORK_W'(longint'(1) << (rmdg_pkg::RND_SH - 1));
		assign cos_rnd = (cos_s33 + HALF) >>> rmdg_pkg::RND_SH;
		assign sin_rnd = (sin_s33 + HALF) >>> rmdg_pkg::RND_SH;
	end else begin : g_nornd
		assign cos_rnd = cos_s33;
		assign sin_rnd = sin_s33;
	end

	always_comb begin
		if (cos_rnd > rmdg_pkg::LIM_HI_W) cos_lim = rmdg_pkg::OUT_HI;
		else if (cos_rnd < rmdg_pkg::LIM_LO_W) cos_lim = rmdg_pkg::OUT_LO;
		else cos_lim = cos_rnd[rmdg_pkg::OUT_W-1:0];
		if (sin_rnd > rmdg_pkg::LIM_HI_W) sin_lim = rmdg_pkg::OUT_HI;
		else if (sin_rnd < rmdg_pkg::LIM_LO_W) sin_lim = rmdg_pkg::OUT_LO;
		else sin_lim = sin_rnd[rmdg_pkg::OUT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_RND] && vld_s[ST_MAP]) begin
			cos_s34 <= cos_lim;
			sin_s34 <= sin_lim;
		end
	end

	// matrix assembly
	rmdg_pkg::entry_t diag, offd;
	rmdg_pkg::entry_t m_nxt [0:8];

	always_comb begin
		diag = (order_q == rmdg_pkg::ORDER_FIRST) ? -sin_s34 : -cos_s34;
		offd = (order_q == rmdg_pkg::ORDER_FIRST) ? cos_s34 : -sin_s34;
		for (int e = 0; e < 9; e++) begin
			m_nxt[e] = '0;
		end
		if (order_q == rmdg_pkg::ORDER_FIRST || order_q == rmdg_pkg::ORDER_SECOND) begin
			case (axis_q)
				rmdg_pkg::AXIS_X: begin
					m_nxt[4] = diag;
					m_nxt[5] = offd;
					m_nxt[7] = -offd;
					m_nxt[8] = diag;
				end
				rmdg_pkg::AXIS_Y: begin
					m_nxt[0] = diag;
					m_nxt[2] = -offd;
					m_nxt[6] = offd;
					m_nxt[8] = diag;
				end
				rmdg_pkg::AXIS_Z: begin
					m_nxt[0] = diag;
					m_nxt[1] = offd;
					m_nxt[3] = -offd;
					m_nxt[4] = diag;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_OUT] && vld_s[ST_RND]) begin
			m_s35 <= m_nxt;
		end
	end

	assign out_valid = vld_s[ST_OUT];
	assign m00 = m_s35[0];
	assign m01 = m_s35[1];
	assign m02 = m_s35[2];
	assign m10 = m_s35[3];
	assign m11 = m_s35[4];
	assign m12 = m_s35[5];
	assign m20 = m_s35[6];
	assign m21 = m_s35[7];
	assign m22 = m_s35[8];

endmodule

// ===== rtl/rmdg_chk.sv =====
module rmdg_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              cfg_ready,
	input logic signed [rmdg_pkg::OUT_W-1:0] m00,
	input logic signed [rmdg_pkg::OUT_W-1:0] m01,
	input logic signed [rmdg_pkg::OUT_W-1:0] m02,
	input logic signed [rmdg_pkg::OUT_W-1:0] m10,
	input logic signed [rmdg_pkg::OUT_W-1:0] m11,
	input logic signed [rmdg_pkg::OUT_W-1:0] m12,
	input logic signed [rmdg_pkg::OUT_W-1:0] m20,
	input logic signed [rmdg_pkg::OUT_W-1:0] m21,
	input logic signed [rmdg_pkg::OUT_W-1:0] m22
);

	// a stalled result holds (valid and six of the nine entries are checked)
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(m11)
		&& $stable(m22) && $stable(m01) && $stable(m12) && $stable(m20))
		else $error("stalled result changed");

	// nothing blocks the input when the output side can move
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready || !out_valid |-> in_ready && cfg_ready)
		else $error("input blocked with output free");

	// at least one row is always all zero, as the row of the rotation axis should be
	a_zero_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (m00 == 0 && m01 == 0 && m02 == 0)
		|| (m10 == 0 && m11 == 0 && m12 == 0)
		|| (m20 == 0 && m21 == 0 && m22 == 0))
		else $error("no zero row in result");

	// diagonal entries stay within the output range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> m00 <= rmdg_pkg::OUT_HI && m00 >= rmdg_pkg::OUT_LO
		&& m11 <= rmdg_pkg::OUT_HI && m11 >= rmdg_pkg::OUT_LO
		&& m22 <= rmdg_pkg::OUT_HI && m22 >= rmdg_pkg::OUT_LO)
		else $error("diagonal entry out of range");

endmodule

bind rotation_matrix_derivative_gen rmdg_chk u_rmdg_chk (.*);

// ===== tb/tb_rotation_matrix_derivative_gen.sv =====
`timescale 1ns / 1ps

module tb_rotation_matrix_derivative_gen;

	localparam int      PIPE_LAT   = 40;
	localparam int      STALL_MAX  = 4000;
	localparam int      RAND_PER   = 88;
	localparam int      CORD_N     = 32;
	localparam longint  X_START    = 652032874;
	localparam int      SCALE_SH   = 30 - rmdg_pkg::FRAC_BITS;
	localparam longint  ONE_Q      = longint'(1) << rmdg_pkg::FRAC_BITS;

	// codes outside the valid register range
	localparam logic [rmdg_pkg::CFG_DATA_W-1:0] AXIS_NONE   = 2'd3;
	localparam logic [rmdg_pkg::CFG_DATA_W-1:0] ORDER_ZERO  = 2'd0;
	localparam logic [rmdg_pkg::CFG_DATA_W-1:0] ORDER_THIRD = 2'd3;
	localparam logic [rmdg_pkg::CFG_IDX_W-1:0]  REG_SPARE2  = 2'd2;
	localparam logic [rmdg_pkg::CFG_IDX_W-1:0]  REG_SPARE3  = 2'd3;

	// atan(2^-i) in units of 2^-32 turn
	localparam longint ATAN_STEP [CORD_N] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	typedef logic [0:8][rmdg_pkg::OUT_W-1:0] matrix_t;

	class rot_deriv_board;
		logic [rmdg_pkg::CFG_DATA_W-1:0] axis_sel;
		logic [rmdg_pkg::CFG_DATA_W-1:0] order_sel;
		matrix_t                         matrix_q[$];
		int                              errors;
		string                           entry_name[9] = '{"m00", "m01", "m02", "m10",
			"m11", "m12", "m20", "m21", "m22"};

		function new();
			axis_sel  = rmdg_pkg::AXIS_X;
			order_sel = rmdg_pkg::ORDER_FIRST;
			errors    = 0;
		endfunction

		function void write_reg(logic [rmdg_pkg::CFG_IDX_W-1:0] idx,
				logic [rmdg_pkg::CFG_DATA_W-1:0] data);
			if (idx == rmdg_pkg::REG_AXIS)
				axis_sel = data;
			else if (idx == rmdg_pkg::REG_ORDER)
				order_sel = data;
		endfunction

		// round half up from 2^30 scale, then clamp to +-1.0 and the 16-bit range
		function longint to_q14(longint v);
			longint r;
			r = (v + (longint'(1) << (SCALE_SH - 1))) >>> SCALE_SH;
			if (r > ONE_Q) r = ONE_Q;
			if (r < -ONE_Q) r = -ONE_Q;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			return r;
		endfunction

		function void sin_cos(logic [rmdg_pkg::IN_W-1:0] ang, output longint s,
				output longint c);
			logic [31:0] turn;
			longint      x, y, z, dx, dy;
			turn = 32'(64'(ang) << (32 - rmdg_pkg::ANGLE_BITS));
			z = longint'(turn[29:0]);
			x = X_START;
			y = 0;
			for (int i = 0; i < CORD_N; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= ATAN_STEP[i];
				end else begin
					x += dx;
					y -= dy;
					z += ATAN_STEP[i];
				end
			end
			case (turn[31:30])
				rmdg_pkg::QUAD_0: begin c = x;  s = y;  end
				rmdg_pkg::QUAD_1: begin c = -y; s = x;  end
				rmdg_pkg::QUAD_2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
			c = to_q14(c);
			s = to_q14(s);
		endfunction

		function void note_request(logic [rmdg_pkg::IN_W-1:0] ang);
			matrix_t m;
			longint  s, c, p, r;
			sin_cos(ang, s, c);
			m = '0;
			if (order_sel == rmdg_pkg::ORDER_FIRST) begin
				p = -s;
				r = c;
			end else begin
				p = -c;
				r = -s;
			end
			if (order_sel == rmdg_pkg::ORDER_FIRST || order_sel == rmdg_pkg::ORDER_SECOND) begin
				case (axis_sel)
					rmdg_pkg::AXIS_X: begin
						m[4] = rmdg_pkg::OUT_W'(p);
						m[5] = rmdg_pkg::OUT_W'(r);
						m[7] = rmdg_pkg::OUT_W'(-r);
						m[8] = rmdg_pkg::OUT_W'(p);
					end
					rmdg_pkg::AXIS_Y: begin
						m[0] = rmdg_pkg::OUT_W'(p);
						m[2] = rmdg_pkg::OUT_W'(-r);
						m[6] = rmdg_pkg::OUT_W'(r);
						m[8] = rmdg_pkg::OUT_W'(p);
					end
					rmdg_pkg::AXIS_Z: begin
						m[0] = rmdg_pkg::OUT_W'(p);
						m[1] = rmdg_pkg::OUT_W'(r);
						m[3] = rmdg_pkg::OUT_W'(-r);
						m[4] = rmdg_pkg::OUT_W'(p);
					end
					default: ;
				endcase
			end
			matrix_q.push_back(m);
		endfunction

		function void check_result(matrix_t got);
			matrix_t want;
			if (matrix_q.size() == 0) begin
				if (errors < 50)
					$error("result with no request pending");
				errors++;
				return;
			end
			want = matrix_q.pop_front();
			for (int k = 0; k < 9; k++) begin
				if (got[k] !== want[k]) begin
					if (errors < 50)
						$error("%s: expected %0d, actual %0d", entry_name[k],
							$signed(want[k]), $signed(got[k]));
					errors++;
				end
			end
		endfunction

		function int pending();
			return matrix_q.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [rmdg_pkg::IN_W-1:0]       angle_turns = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	rmdg_pkg::entry_t                m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [rmdg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rmdg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	rot_deriv_board board = new();
	int                    burst_left = 0;
	int                    idle_cycles = 0;
	int                    ready_pct = 100;
	int                    ready_window = 0;

	rotation_matrix_derivative_gen dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.angle_turns (angle_turns),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.m00         (m00),
		.m01         (m01),
		.m02         (m02),
		.m10         (m10),
		.m11         (m11),
		.m12         (m12),
		.m20         (m20),
		.m21         (m21),
		.m22         (m22),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				board.note_request(angle_turns);
			if (out_valid && out_ready)
				board.check_result({m00, m01, m02, m10, m11, m12, m20, m21, m22});
		end
	end

	// receiver back-pressure: a ready rate held for a random window
	always @(posedge clk) begin
		if (ready_window == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pct <= 100;
				1: ready_pct <= 75;
				2: ready_pct <= 40;
				default: ready_pct <= 10;
			endcase
			ready_window <= $urandom_range(16, 96);
		end else begin
			ready_window <= ready_window - 1;
		end
		out_ready <= ($urandom_range(1, 100) <= ready_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_MAX) begin
			$display("tb_rotation_matrix_derivative_gen: done, errors");
			$finish;
		end
	end

	// leaves in_valid high on return; caller sends again or drops it in the same step
	task automatic send_angle(input logic [rmdg_pkg::IN_W-1:0] ang);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		angle_turns <= ang;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [rmdg_pkg::CFG_IDX_W-1:0] idx,
			input logic [rmdg_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [rmdg_pkg::CFG_DATA_W-1:0] axis,
			input logic [rmdg_pkg::CFG_DATA_W-1:0] order, input bit spare);
		in_valid <= 1'b0;
		wait_drained();
		repeat (PIPE_LAT) @(posedge clk);
		cfg_write(rmdg_pkg::REG_AXIS, axis);
		// writes past the register list must not land anywhere
		if (spare) begin
			cfg_write(REG_SPARE2, AXIS_NONE);
			cfg_write(REG_SPARE3, ORDER_ZERO);
		end
		cfg_write(rmdg_pkg::REG_ORDER, order);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	logic [rmdg_pkg::IN_W-1:0] corner_angle [12] = '{16'h0000, 16'hFFFF, 16'h4000,
		16'h8000, 16'hC000, 16'h3FFF, 16'h7FFF, 16'hBFFF, 16'h0001, 16'h2000, 16'h5555,
		16'hAAAA};
	logic [rmdg_pkg::CFG_DATA_W-1:0] dir_axis [5] = '{rmdg_pkg::AXIS_Y, rmdg_pkg::AXIS_Z,
		AXIS_NONE, rmdg_pkg::AXIS_X, rmdg_pkg::AXIS_Z};
	logic [rmdg_pkg::CFG_DATA_W-1:0] dir_order [5] = '{rmdg_pkg::ORDER_SECOND,
		rmdg_pkg::ORDER_SECOND, rmdg_pkg::ORDER_FIRST, ORDER_ZERO, ORDER_THIRD};

	initial begin
		logic [rmdg_pkg::IN_W-1:0] ang;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner angles under the reset setting
		foreach (corner_angle[k])
			send_angle(corner_angle[k]);

		for (int k = 0; k < 5; k++) begin
			set_config(dir_axis[k], dir_order[k], k == 0);
			send_angle(corner_angle[(2 * k + 1) % 12]);
			send_angle(corner_angle[(2 * k + 6) % 12]);
		end

		// random angles under every axis and order code
		for (int ph = 0; ph < 16; ph++) begin
			set_config(ph[1:0], ph[3:2], 1'b0);
			for (int n = 0; n < RAND_PER; n++) begin
				case ($urandom_range(0, 7))
					0: ang = {2'($urandom), 14'($urandom_range(0, 7))};
					1: ang = {2'($urandom), 14'(16383 - $urandom_range(0, 7))};
					2: ang = rmdg_pkg::IN_W'($urandom_range(0, 255));
					default: ang = rmdg_pkg::IN_W'($urandom);
				endcase
				// hold off until the pipeline has emptied, then resume
				if (ph == 5 && n == 40) begin
					in_valid <= 1'b0;
					wait_drained();
				end
				send_angle(ang);
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (PIPE_LAT) @(posedge clk);
		if (board.errors == 0)
			$display("tb_rotation_matrix_derivative_gen: done, clean");
		else
			$display("tb_rotation_matrix_derivative_gen: done, errors");
		$finish;
	end

endmodule
